// ===== rtl/phv_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and saturating score arithmetic for the Viterbi scorer.
package phv_pkg;

  localparam int SCORE_W       = 32;
  localparam int MAX_NODES_DEF = 1024;
  localparam int ALPHA_DEF     = 32;
  localparam int NUM_TRANS     = 8;
  localparam int NODE_IN_W     = 11;
  localparam int KIND_W        = 5;
  localparam int RES_IN_W      = 5;
  localparam int SPEC_IDX_W    = 3;
  localparam int CFG_IDX_W     = 1;
  localparam int CFG_DATA_W    = 11;

  typedef logic signed [SCORE_W-1:0] score_t;
  typedef score_t [NUM_TRANS-1:0] trans_vec_t;

  localparam score_t NEG_INF = {1'b1, {(SCORE_W-1){1'b0}}};
  localparam score_t POS_MAX = {1'b0, {(SCORE_W-1){1'b1}}};

  typedef enum logic [KIND_W-1:0] {
    K_MM     = 5'd0,
    K_IM     = 5'd1,
    K_DM     = 5'd2,
    K_BM     = 5'd3,
    K_MI     = 5'd4,
    K_II     = 5'd5,
    K_MD     = 5'd6,
    K_DD     = 5'd7,
    K_ELOOP  = 5'd8,
    K_EMOVE  = 5'd9,
    K_NLOOP  = 5'd10,
    K_NMOVE  = 5'd11,
    K_JLOOP  = 5'd12,
    K_JMOVE  = 5'd13,
    K_CLOOP  = 5'd14,
    K_CMOVE  = 5'd15,
    K_MATCH  = 5'd16,
    K_INSERT = 5'd17
  } kind_e;

  localparam logic ACT_LOAD    = 1'b0;
  localparam logic ACT_RESIDUE = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_MODEL_LEN = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_LOCAL     = 1'b1;

  typedef struct packed {
    logic valid;
    logic last;
  } ctl_t;

  typedef struct packed {
    logic   valid;
    score_t m;
    score_t i;
    score_t d;
  } wb_t;

  function automatic score_t sat_add(score_t a, score_t b);
    logic signed [SCORE_W:0] s;
    s = {a[SCORE_W-1], a} + {b[SCORE_W-1], b};
    if (a == NEG_INF || b == NEG_INF) begin
      return NEG_INF;
    end else if (s[SCORE_W] != s[SCORE_W-1]) begin
      return s[SCORE_W] ? NEG_INF : POS_MAX;
    end else begin
      return s[SCORE_W-1:0];
    end
  endfunction

  function automatic score_t smax(score_t a, score_t b);
    return (a > b) ? a : b;
  endfunction

endpackage

// ===== rtl/phv_score_store.sv =====
`timescale 1ns / 1ps
// Transition and emission score memories with load port and node-walk read port.
module phv_score_store import phv_pkg::*; #(
  parameter int MAX_NODES     = MAX_NODES_DEF,
  parameter int ALPHABET_SIZE = ALPHA_DEF,
  localparam int ROWS   = MAX_NODES + 1,
  localparam int NODE_W = $clog2(ROWS),
  localparam int RES_W  = $clog2(ALPHABET_SIZE),
  localparam int EMIS_DEPTH = ROWS * (2 ** RES_W)
) (
  input  logic              clk_i,
  input  logic              ld_en_i,
  input  logic [NODE_W-1:0] ld_node_i,
  input  logic [KIND_W-1:0] ld_kind_i,
  input  logic [RES_W-1:0]  ld_res_i,
  input  score_t            ld_value_i,
  input  logic [NODE_W-1:0] rd_t_i,
  input  logic [RES_W-1:0]  rd_res_i,
  output trans_vec_t        trans_o,
  output score_t            match_em_o,
  output score_t            ins_em_o
);

  logic [NODE_W-1:0] rd_prev;
  assign rd_prev = rd_t_i - NODE_W'(1);

  for (genvar k = 0; k < NUM_TRANS; k++) begin : g_trans
    score_t mem [ROWS];
    score_t rd_q;
    logic [NODE_W-1:0] rd_addr;
    assign rd_addr = (k == int'(K_MI) || k == int'(K_II)) ? rd_t_i : rd_prev;
    always_ff @(posedge clk_i) begin
      if (ld_en_i && ld_kind_i == KIND_W'(k)) begin
        mem[ld_node_i] <= ld_value_i;
      end
      rd_q <= mem[rd_addr];
    end
    assign trans_o[k] = rd_q;
  end

  score_t match_mem [EMIS_DEPTH];
  score_t ins_mem   [EMIS_DEPTH];

  always_ff @(posedge clk_i) begin
    if (ld_en_i && ld_kind_i == K_MATCH) begin
      match_mem[{ld_node_i, ld_res_i}] <= ld_value_i;
    end
    if (ld_en_i && ld_kind_i == K_INSERT) begin
      ins_mem[{ld_node_i, ld_res_i}] <= ld_value_i;
    end
    match_em_o <= match_mem[{rd_t_i, rd_res_i}];
    ins_em_o   <= ins_mem[{rd_t_i, rd_res_i}];
  end

endmodule

// ===== rtl/phv_row_store.sv =====
`timescale 1ns / 1ps
// Match, insert and delete row memories of the DP.
module phv_row_store import phv_pkg::*; #(
  parameter int MAX_NODES = MAX_NODES_DEF,
  localparam int ROWS   = MAX_NODES + 1,
  localparam int NODE_W = $clog2(ROWS)
) (
  input  logic              clk_i,
  input  wb_t               wr_i,
  input  logic [NODE_W-1:0] wr_addr_i,
  input  logic [NODE_W-1:0] rd_addr_i,
  output score_t            om_o,
  output score_t            oi_o,
  output score_t            od_o
);

  score_t m_mem [ROWS];
  score_t i_mem [ROWS];
  score_t d_mem [ROWS];

  always_ff @(posedge clk_i) begin
    if (wr_i.valid) begin
      m_mem[wr_addr_i] <= wr_i.m;
      i_mem[wr_addr_i] <= wr_i.i;
      d_mem[wr_addr_i] <= wr_i.d;
    end
    om_o <= m_mem[rd_addr_i];
    oi_o <= i_mem[rd_addr_i];
    od_o <= d_mem[rd_addr_i];
  end

endmodule

// ===== rtl/phv_cell_pipe.sv =====
`timescale 1ns / 1ps
// Pipelined M/I/D cell update, delete recurrence and end-state accumulation.
module phv_cell_pipe import phv_pkg::*; #(
  parameter int MAX_NODES = MAX_NODES_DEF,
  localparam int NODE_W = $clog2(MAX_NODES + 1)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ctl_t              iss_i,
  input  logic [NODE_W-1:0] iss_t_i,
  input  logic              pass_start_i,
  input  score_t            bprev_i,
  input  logic              local_i,
  input  logic              emis_ok_i,
  input  score_t            om_i,
  input  score_t            oi_i,
  input  score_t            od_i,
  input  trans_vec_t        tp_i,
  input  score_t            me_i,
  input  score_t            ie_i,
  output wb_t               wb_o,
  output logic [NODE_W-1:0] wb_t_o,
  output score_t            e_o,
  output logic              done_o
);

  ctl_t              p1_q, s1_q, s2_q, s3_q;
  logic [NODE_W-1:0] p1_t_q, s1_t_q, s2_t_q, s3_t_q;
  score_t            prev_om_q, prev_oi_q, prev_od_q;
  score_t            s1_a0_q, s1_a1_q, s1_a2_q, s1_a3_q, s1_i0_q, s1_i1_q;
  score_t            s1_me_q, s1_ie_q, s1_md_q, s1_dd_q;
  score_t            s2_best_q, s2_ib_q, s2_me_q, s2_ie_q, s2_md_q, s2_dd_q;
  score_t            s3_m_q, s3_i_q, s3_md_q, s3_dd_q;
  score_t            lm_q, ld_q, e_q;
  score_t            d_new;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_q <= '0;
      s1_q <= '0;
      s2_q <= '0;
      s3_q <= '0;
    end else begin
      p1_q <= iss_i;
      s1_q <= p1_q;
      s2_q <= s1_q;
      s3_q <= s2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    p1_t_q <= iss_t_i;
    s1_t_q <= p1_t_q;
    s2_t_q <= s1_t_q;
    s3_t_q <= s2_t_q;

    s1_a0_q <= sat_add(prev_om_q, tp_i[K_MM]);
    s1_a1_q <= sat_add(prev_oi_q, tp_i[K_IM]);
    s1_a2_q <= sat_add(prev_od_q, tp_i[K_DM]);
    s1_a3_q <= sat_add(bprev_i, tp_i[K_BM]);
    s1_i0_q <= sat_add(om_i, tp_i[K_MI]);
    s1_i1_q <= sat_add(oi_i, tp_i[K_II]);
    s1_me_q <= emis_ok_i ? me_i : NEG_INF;
    s1_ie_q <= emis_ok_i ? ie_i : NEG_INF;
    s1_md_q <= tp_i[K_MD];
    s1_dd_q <= tp_i[K_DD];

    s2_best_q <= smax(smax(s1_a0_q, s1_a1_q), smax(s1_a2_q, s1_a3_q));
    s2_ib_q   <= smax(s1_i0_q, s1_i1_q);
    s2_me_q   <= s1_me_q;
    s2_ie_q   <= s1_ie_q;
    s2_md_q   <= s1_md_q;
    s2_dd_q   <= s1_dd_q;

    s3_m_q  <= sat_add(s2_best_q, s2_me_q);
    s3_i_q  <= s2_q.last ? NEG_INF : sat_add(s2_ib_q, s2_ie_q);
    s3_md_q <= s2_md_q;
    s3_dd_q <= s2_dd_q;

    if (pass_start_i) begin
      prev_om_q <= NEG_INF;
      prev_oi_q <= NEG_INF;
      prev_od_q <= NEG_INF;
      lm_q      <= NEG_INF;
      ld_q      <= NEG_INF;
      e_q       <= NEG_INF;
    end else begin
      if (p1_q.valid) begin
        prev_om_q <= om_i;
        prev_oi_q <= oi_i;
        prev_od_q <= od_i;
      end
      if (s3_q.valid) begin
        lm_q <= s3_m_q;
        ld_q <= d_new;
        if (s3_q.last) begin
          e_q <= smax(e_q, smax(s3_m_q, d_new));
        end else if (local_i) begin
          e_q <= smax(e_q, s3_m_q);
        end
      end
    end
  end

  assign d_new   = smax(sat_add(lm_q, s3_md_q), sat_add(ld_q, s3_dd_q));
  assign wb_o    = '{valid: s3_q.valid, m: s3_m_q, i: s3_i_q, d: d_new};
  assign wb_t_o  = s3_t_q;
  assign e_o     = e_q;
  assign done_o  = s3_q.valid && s3_q.last;

endmodule

// ===== rtl/profile_hmm_viterbi_score_core.sv =====
`timescale 1ns / 1ps
// Top level: item intake, node-walk sequencer, special states and result beat.
//
// Input channel (in_valid_i/in_ready_o) takes one beat per item. A load beat
// (action 0) writes one score word. A residue beat (action 1) walks nodes
// 1..T one per cycle through the row memories and a four-stage cell
// pipeline, then updates N, J, C and B; no new beat is taken until the
// pass is done. The last residue of a query also returns one result beat on
// out_valid_o/final_score_o and then clears the three row memories, one node
// per cycle, before the next accept. After reset the same clearing pass runs
// before the first input beat is taken; configuration writes (cfg_valid_i)
// are taken in every cycle. The result sits in an output register: further
// loads and residues are taken while it waits, and only the next query end
// holds until the receiver takes it.
module profile_hmm_viterbi_score_core import phv_pkg::*; #(
  parameter int MAX_NODES     = MAX_NODES_DEF,
  parameter int ALPHABET_SIZE = ALPHA_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic                  action_i,
  input  logic [NODE_IN_W-1:0]  node_index_i,
  input  logic [KIND_W-1:0]     score_kind_i,
  input  logic [RES_IN_W-1:0]   residue_i,
  input  score_t                score_value_i,
  input  logic                  last_residue_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output score_t                final_score_o
);

  localparam int NODE_W = $clog2(MAX_NODES + 1);
  localparam int RES_W  = $clog2(ALPHABET_SIZE);
  localparam logic [NODE_W-1:0] LAST_NODE = NODE_W'(MAX_NODES);

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_RUN, S_DRAIN, S_FIN1, S_FIN2
  } state_e;

  state_e                state_q;
  logic [NODE_W-1:0]     clr_idx_q, run_t_q, tlen;
  logic [CFG_DATA_W-1:0] ml_q;
  logic                  local_q, last_q, res_ok_q, row_zero_q, out_valid_q;
  logic [RES_W-1:0]      res_q;
  score_t                n_q, b_q, c_q, j_q, out_q, bprev, e;
  score_t                spec_q [NUM_TRANS];
  logic                  accept, ld_node_ok, ld_res_ok, ld_en, pass_start, done;
  logic                  emit;
  ctl_t                  iss;
  wb_t                   pipe_wb, row_wr;
  logic [NODE_W-1:0]     pipe_wb_t, row_wr_addr;
  score_t                om, oi, od, me, ie;
  trans_vec_t            tp;

  assign cfg_ready_o   = 1'b1;
  assign in_ready_o    = (state_q == S_IDLE);
  assign out_valid_o   = out_valid_q;
  assign final_score_o = out_q;
  assign accept        = in_valid_i && in_ready_o;
  assign emit          = (state_q == S_FIN2) && last_q && (!out_valid_q || out_ready_i);

  always_comb begin
    if (ml_q == '0) begin
      tlen = NODE_W'(1);
    end else if (32'(ml_q) > MAX_NODES) begin
      tlen = LAST_NODE;
    end else begin
      tlen = NODE_W'(ml_q);
    end
  end

  assign ld_node_ok = 32'(node_index_i) <= MAX_NODES;
  assign ld_res_ok  = 32'(residue_i) < ALPHABET_SIZE;
  assign ld_en      = accept && action_i == ACT_LOAD && ld_node_ok &&
                      (score_kind_i < K_ELOOP ||
                       ((score_kind_i == K_MATCH || score_kind_i == K_INSERT) && ld_res_ok));
  assign pass_start = accept && action_i == ACT_RESIDUE;

  assign iss.valid = (state_q == S_RUN);
  assign iss.last  = (run_t_q == tlen);
  assign bprev     = row_zero_q ? spec_q[SPEC_IDX_W'(K_NMOVE)] : b_q;

  always_comb begin
    if (state_q == S_CLEAR) begin
      row_wr      = '{valid: 1'b1, m: NEG_INF, i: NEG_INF, d: NEG_INF};
      row_wr_addr = clr_idx_q;
    end else begin
      row_wr      = pipe_wb;
      row_wr_addr = pipe_wb_t;
    end
  end

  phv_score_store #(
    .MAX_NODES    (MAX_NODES),
    .ALPHABET_SIZE(ALPHABET_SIZE)
  ) u_store (
    .clk_i     (clk_i),
    .ld_en_i   (ld_en),
    .ld_node_i (NODE_W'(node_index_i)),
    .ld_kind_i (score_kind_i),
    .ld_res_i  (RES_W'(residue_i)),
    .ld_value_i(score_value_i),
    .rd_t_i    (run_t_q),
    .rd_res_i  (res_q),
    .trans_o   (tp),
    .match_em_o(me),
    .ins_em_o  (ie)
  );

  phv_row_store #(
    .MAX_NODES(MAX_NODES)
  ) u_rows (
    .clk_i    (clk_i),
    .wr_i     (row_wr),
    .wr_addr_i(row_wr_addr),
    .rd_addr_i(run_t_q),
    .om_o     (om),
    .oi_o     (oi),
    .od_o     (od)
  );

  phv_cell_pipe #(
    .MAX_NODES(MAX_NODES)
  ) u_pipe (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .iss_i       (iss),
    .iss_t_i     (run_t_q),
    .pass_start_i(pass_start),
    .bprev_i     (bprev),
    .local_i     (local_q),
    .emis_ok_i   (res_ok_q),
    .om_i        (om),
    .oi_i        (oi),
    .od_i        (od),
    .tp_i        (tp),
    .me_i        (me),
    .ie_i        (ie),
    .wb_o        (pipe_wb),
    .wb_t_o      (pipe_wb_t),
    .e_o         (e),
    .done_o      (done)
  );

  always_ff @(posedge clk_i) begin
    if (accept && action_i == ACT_LOAD && score_kind_i >= K_ELOOP &&
        score_kind_i <= K_CMOVE) begin
      spec_q[score_kind_i[SPEC_IDX_W-1:0]] <= score_value_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_idx_q   <= NODE_W'(1);
      run_t_q     <= NODE_W'(1);
      ml_q        <= CFG_DATA_W'(1);
      local_q     <= 1'b1;
      last_q      <= 1'b0;
      res_ok_q    <= 1'b0;
      res_q       <= '0;
      row_zero_q  <= 1'b1;
      out_valid_q <= 1'b0;
      out_q       <= '0;
      n_q         <= '0;
      b_q         <= NEG_INF;
      c_q         <= NEG_INF;
      j_q         <= NEG_INF;
    end else begin
      if (cfg_valid_i) begin
        case (cfg_index_i)
          CFG_MODEL_LEN: ml_q    <= cfg_data_i;
          CFG_LOCAL:     local_q <= cfg_data_i[0];
          default: ;
        endcase
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_CLEAR: begin
          if (clr_idx_q == LAST_NODE) begin
            clr_idx_q <= NODE_W'(1);
            state_q   <= S_IDLE;
          end else begin
            clr_idx_q <= clr_idx_q + NODE_W'(1);
          end
        end
        S_IDLE: begin
          if (pass_start) begin
            res_q    <= RES_W'(residue_i);
            res_ok_q <= ld_res_ok;
            last_q   <= last_residue_i;
            run_t_q  <= NODE_W'(1);
            state_q  <= S_RUN;
          end
        end
        S_RUN: begin
          if (iss.last) begin
            state_q <= S_DRAIN;
          end else begin
            run_t_q <= run_t_q + NODE_W'(1);
          end
        end
        S_DRAIN: begin
          if (done) begin
            state_q <= S_FIN1;
          end
        end
        S_FIN1: begin
          n_q     <= sat_add(n_q, spec_q[SPEC_IDX_W'(K_NLOOP)]);
          j_q     <= smax(sat_add(j_q, spec_q[SPEC_IDX_W'(K_JLOOP)]),
                          sat_add(e, spec_q[SPEC_IDX_W'(K_ELOOP)]));
          c_q     <= smax(sat_add(c_q, spec_q[SPEC_IDX_W'(K_CLOOP)]),
                          sat_add(e, spec_q[SPEC_IDX_W'(K_EMOVE)]));
          state_q <= S_FIN2;
        end
        S_FIN2: begin
          if (!last_q) begin
            b_q        <= smax(sat_add(n_q, spec_q[SPEC_IDX_W'(K_NMOVE)]),
                               sat_add(j_q, spec_q[SPEC_IDX_W'(K_JMOVE)]));
            row_zero_q <= 1'b0;
            state_q    <= S_IDLE;
          end else if (emit) begin
            out_q       <= sat_add(c_q, spec_q[SPEC_IDX_W'(K_CMOVE)]);
            n_q         <= '0;
            b_q         <= NEG_INF;
            c_q         <= NEG_INF;
            j_q         <= NEG_INF;
            row_zero_q  <= 1'b1;
            clr_idx_q   <= NODE_W'(1);
            state_q     <= S_CLEAR;
          end
        end
        default: state_q <= S_CLEAR;
      endcase
    end
  end

`ifndef SYNTH
  a_clear_no_wb: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_CLEAR |-> !pipe_wb.valid)
    else $error("row writeback during clearing pass");

  a_issue_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    iss.valid |-> (run_t_q != '0 && run_t_q <= tlen))
    else $error("node walk outside 1..T");

  a_done_in_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done |-> state_q == S_DRAIN)
    else $error("pass end outside drain");

  a_result_from_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == S_FIN2 && $past(last_q))
    else $error("result beat without query end");
`endif

endmodule

// ===== tb/profile_hmm_viterbi_score_core_tb.sv =====
`timescale 1ns / 1ps
// Testbench for the Viterbi scorer: drives loads and residues, predicts final scores.
module profile_hmm_viterbi_score_core_tb;
  import phv_pkg::*;

  localparam int NODES    = 1024;
  localparam int ALPHA    = 32;
  localparam int USED     = 8;
  localparam int RES_USED = 4;
  localparam int LIMIT    = 4000000;
  localparam int SETTLE   = NODES + 64;

  class viterbi_scoreboard;
    score_t mrow[0:NODES];
    score_t irow[0:NODES];
    score_t drow[0:NODES];
    score_t trans[0:(NODES+1)*8-1];
    score_t mem_m[0:(NODES+1)*ALPHA-1];
    score_t mem_i[0:(NODES+1)*ALPHA-1];
    score_t spec[0:7];
    score_t st_n, st_b, st_e, st_c, st_j;
    bit     row_zero;
    int     model_len;
    bit     loc_mode;
    score_t expected_scores[$];
    int     errors;

    function new();
      foreach (trans[k]) trans[k] = '0;
      foreach (mem_m[k]) mem_m[k] = '0;
      foreach (mem_i[k]) mem_i[k] = '0;
      foreach (spec[k]) spec[k] = '0;
      model_len = 1;
      loc_mode  = 1'b1;
      errors    = 0;
      clear_query();
    endfunction

    function void clear_query();
      for (int k = 0; k <= NODES; k++) begin
        mrow[k] = NEG_INF;
        irow[k] = NEG_INF;
        drow[k] = NEG_INF;
      end
      st_n = '0;
      st_b = NEG_INF;
      st_e = NEG_INF;
      st_c = NEG_INF;
      st_j = NEG_INF;
      row_zero = 1'b1;
    endfunction

    function score_t add_sc(score_t a, score_t b);
      longint s;
      if (a == NEG_INF || b == NEG_INF) return NEG_INF;
      s = longint'(a) + longint'(b);
      if (s > 64'sd2147483647) return 32'sh7fffffff;
      if (s < -64'sd2147483648) return NEG_INF;
      return score_t'(s[31:0]);
    endfunction

    function score_t max_sc(score_t a, score_t b);
      return (a > b) ? a : b;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      if (idx == CFG_MODEL_LEN) model_len = data;
      else loc_mode = data[0];
    endfunction

    function void note_item(logic act, logic [10:0] node, logic [4:0] kind,
                            logic [4:0] res, score_t v, logic fin);
      int     tlen;
      score_t dm, di, dd, lm, ld, bprev, e, jn, cn, nn, bn;
      score_t om, oi, od, me, ie, m, i, d, best;
      if (act == ACT_LOAD) begin
        if (kind >= K_ELOOP && kind <= K_CMOVE) spec[kind - 8] = v;
        else if (node <= NODES) begin
          if (kind <= K_DD) trans[node*8 + kind] = v;
          else if (kind == K_MATCH) mem_m[node*ALPHA + res] = v;
          else if (kind == K_INSERT) mem_i[node*ALPHA + res] = v;
        end
        return;
      end
      tlen = (model_len < 1) ? 1 : (model_len > NODES) ? NODES : model_len;
      bprev = row_zero ? spec[3] : st_b;
      dm = mrow[0]; di = irow[0]; dd = drow[0];
      lm = NEG_INF; ld = NEG_INF; e = NEG_INF;
      for (int t = 1; t <= tlen; t++) begin
        om = mrow[t]; oi = irow[t]; od = drow[t];
        me = mem_m[t*ALPHA + res];
        best = max_sc(max_sc(add_sc(dm, trans[(t-1)*8 + K_MM]), add_sc(di, trans[(t-1)*8 + K_IM])),
                      max_sc(add_sc(dd, trans[(t-1)*8 + K_DM]),
                             add_sc(bprev, trans[(t-1)*8 + K_BM])));
        m = add_sc(best, me);
        if (t < tlen) begin
          ie = mem_i[t*ALPHA + res];
          i = add_sc(max_sc(add_sc(om, trans[t*8 + K_MI]), add_sc(oi, trans[t*8 + K_II])), ie);
        end else begin
          i = NEG_INF;
        end
        d = max_sc(add_sc(lm, trans[(t-1)*8 + K_MD]), add_sc(ld, trans[(t-1)*8 + K_DD]));
        if (t < tlen) begin
          if (loc_mode) e = max_sc(e, m);
        end else begin
          e = max_sc(e, max_sc(m, d));
        end
        mrow[t] = m; irow[t] = i; drow[t] = d;
        dm = om; di = oi; dd = od;
        lm = m; ld = d;
      end
      mrow[0] = NEG_INF; irow[0] = NEG_INF; drow[0] = NEG_INF;
      jn = max_sc(add_sc(st_j, spec[4]), add_sc(e, spec[0]));
      cn = max_sc(add_sc(st_c, spec[6]), add_sc(e, spec[1]));
      nn = add_sc(st_n, spec[2]);
      bn = max_sc(add_sc(nn, spec[3]), add_sc(jn, spec[5]));
      st_n = nn; st_b = bn; st_e = e; st_c = cn; st_j = jn;
      row_zero = 1'b0;
      if (fin) begin
        expected_scores.push_back(add_sc(cn, spec[7]));
        clear_query();
      end
    endfunction

    task report(string msg);
      $display("mismatch: %s", msg);
      errors++;
    endtask

    task check_result(score_t got);
      score_t want;
      if (expected_scores.size() == 0) begin
        report($sformatf("unexpected final_score %0d", got));
      end else begin
        want = expected_scores.pop_front();
        if (got !== want) report($sformatf("final_score %0d, want %0d", got, want));
      end
    endtask
  endclass

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  logic                  in_valid_i = 1'b0;
  logic                  in_ready_o;
  logic                  action_i = 1'b0;
  logic [NODE_IN_W-1:0]  node_index_i = '0;
  logic [KIND_W-1:0]     score_kind_i = '0;
  logic [RES_IN_W-1:0]   residue_i = '0;
  score_t                score_value_i = '0;
  logic                  last_residue_i = 1'b0;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  score_t                final_score_o;

  viterbi_scoreboard sb = new();
  bit quiet = 1'b0;
  int cycles = 0;
  int rand_items = 0;

  always #10 clk_i = ~clk_i;

  profile_hmm_viterbi_score_core u_dut (.*);

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) sb.check_result(final_score_o);
    out_ready_i <= quiet || ($urandom_range(0, 99) >= 23);
  end

  function automatic score_t rnd_score();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return score_t'($signed($urandom_range(0, 6000)) - 4000);
    if (r < 85) return score_t'($urandom);
    if (r < 92) return NEG_INF;
    return score_t'($signed($urandom_range(0, 1000)) + 32'sh7ffffc00);
  endfunction

  task automatic send(logic act, logic [10:0] node, logic [4:0] kind, logic [4:0] res,
                      score_t v, logic fin);
    if (!quiet && $urandom_range(0, 99) < 23) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    action_i       <= act;
    node_index_i   <= node;
    score_kind_i   <= kind;
    residue_i      <= res;
    score_value_i  <= v;
    last_residue_i <= fin;
    in_valid_i     <= 1'b1;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sb.note_item(act, node, kind, res, v, fin);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.expected_scores.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic set_mode(logic [10:0] len, logic loc);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= CFG_MODEL_LEN;
    cfg_data_i  <= len;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    sb.set_reg(CFG_MODEL_LEN, len);
    cfg_index_i <= CFG_LOCAL;
    cfg_data_i  <= {10'($urandom), loc};
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    sb.set_reg(CFG_LOCAL, cfg_data_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic random_load();
    if ($urandom_range(0, 99) < 25) begin
      if ($urandom_range(0, 1))
        send(ACT_LOAD, 11'($urandom_range(NODES + 1, 2047)), 5'($urandom_range(0, 17)),
             5'($urandom), score_t'($urandom), 1'($urandom));
      else
        send(ACT_LOAD, 11'($urandom), 5'($urandom_range(18, 31)), 5'($urandom),
             score_t'($urandom), 1'($urandom));
    end else begin
      send(ACT_LOAD, 11'($urandom_range(0, NODES)), 5'($urandom_range(0, 17)),
           5'($urandom), rnd_score(), 1'($urandom));
    end
    rand_items++;
  endtask

  int lens[10] = '{1, 1, 0, 2, 5, 8, 7, 3, 6, 4};
  bit locs[10] = '{1, 0, 1, 0, 1, 0, 1, 0, 1, 0};

  initial begin
    int budget, nres, ph;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    set_mode(11'd1, 1'b1);

    for (int n = 0; n < USED; n++)
      for (int k = K_MM; k <= K_DD; k++)
        send(ACT_LOAD, 11'(n), 5'(k), 5'($urandom), rnd_score(), 1'b0);
    for (int k = K_ELOOP; k <= K_CMOVE; k++)
      send(ACT_LOAD, 11'($urandom), 5'(k), 5'($urandom), rnd_score(), 1'b0);
    for (int n = 1; n <= USED; n++)
      for (int r = 0; r < RES_USED; r++) begin
        send(ACT_LOAD, 11'(n), K_MATCH, 5'(r), rnd_score(), 1'b0);
        send(ACT_LOAD, 11'(n), K_INSERT, 5'(r), rnd_score(), 1'b0);
      end

    send(ACT_LOAD, 11'd0, K_MM, 5'd0, 32'sh7fffffff, 1'b1);
    send(ACT_LOAD, 11'd1, K_MATCH, 5'd0, NEG_INF, 1'b0);
    send(ACT_RESIDUE, 11'd0, K_MM, 5'd0, '0, 1'b1);
    send(ACT_LOAD, 11'd0, K_BM, 5'd0, 32'sh7fffffff, 1'b0);
    send(ACT_LOAD, 11'd1, K_MATCH, 5'd31, 32'sh7fffffff, 1'b0);
    send(ACT_LOAD, 11'd0, K_CMOVE, 5'd0, 32'sh7fffffff, 1'b0);
    send(ACT_LOAD, 11'd0, K_EMOVE, 5'd0, '0, 1'b0);
    send(ACT_RESIDUE, 11'h7ff, 5'h1f, 5'd31, 32'hffffffff, 1'b1);
    send(ACT_LOAD, 11'h7ff, K_MM, 5'd0, NEG_INF, 1'b0);
    send(ACT_LOAD, 11'd5, 5'd31, 5'd0, NEG_INF, 1'b0);
    send(ACT_LOAD, 11'd1024, K_MATCH, 5'd31, NEG_INF, 1'b1);
    send(ACT_LOAD, 11'd0, K_CMOVE, 5'd0, NEG_INF, 1'b0);
    send(ACT_RESIDUE, 11'd0, K_MM, 5'd1, '0, 1'b1);
    send(ACT_LOAD, 11'd0, K_CMOVE, 5'd0, 32'sh80000001, 1'b0);
    send(ACT_LOAD, 11'd0, K_BM, 5'd0, -32'sd500, 1'b0);
    send(ACT_LOAD, 11'd1, K_MATCH, 5'd0, -32'sd700, 1'b0);
    send(ACT_RESIDUE, 11'd0, K_MM, 5'd0, '0, 1'b0);
    send(ACT_RESIDUE, 11'd0, K_MM, 5'd2, '0, 1'b0);
    send(ACT_RESIDUE, 11'd0, K_MM, 5'd0, '0, 1'b1);
    send(ACT_LOAD, 11'd0, K_CMOVE, 5'd0, '0, 1'b0);
    drain();

    ph = 0;
    while (rand_items < 400 || ph < 10) begin
      set_mode(11'(lens[ph % 10]), locs[ph % 10]);
      quiet = (ph == 2);
      budget = rand_items + 40;
      while (rand_items < budget) begin
        nres = $urandom_range(1, 6);
        for (int q = 0; q < nres; q++) begin
          repeat ($urandom_range(0, 2)) random_load();
          send(ACT_RESIDUE, 11'($urandom), 5'($urandom),
               5'($urandom_range(0, RES_USED - 1)),
               score_t'($urandom), q == nres - 1);
          rand_items++;
        end
      end
      quiet = 1'b0;
      drain();
      ph++;
    end

    if (sb.expected_scores.size() != 0) sb.report("final scores still outstanding");
    if (sb.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/phv_pkg.sv
rtl/phv_score_store.sv
rtl/phv_row_store.sv
rtl/phv_cell_pipe.sv
rtl/profile_hmm_viterbi_score_core.sv
tb/profile_hmm_viterbi_score_core_tb.sv
